// ===== rtl/core/deadline_task_dispatcher_defines.svh =====
// assertion macros for the deadline task dispatcher checker
// expects clk_i and rst_ni in the scope of each use
`ifndef DEADLINE_TASK_DISPATCHER_DEFINES_SVH
`define DEADLINE_TASK_DISPATCHER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DTD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that forces another condition in the next cycle
`define DTD_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/dtd_pkg.sv =====
// shared types, constants and helpers of the deadline task dispatcher
// no dependencies
`default_nettype none

package dtd_pkg;

  localparam int TaskSlots    = 16;
  localparam int ListDepth    = 8;
  localparam int ForcePeriod  = 8000;
  localparam int TimeBits     = 48;
  localparam int DefaultRuntime = 1;
  localparam int FlagBits     = 32;

  localparam int SlotW = $clog2(TaskSlots);
  localparam int IdxW  = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int CntW  = $clog2(ListDepth + 1);

  localparam int InDataW  = 160;
  localparam int OutDataW = 16;

  // type bits
  localparam int TReq = 0;
  localparam int TMot = 1;
  localparam int TRec = 2;
  localparam int TOpt = 3;
  localparam int TRap = 4;
  localparam int TShd = 5;

  typedef enum logic [2:0] {
    KindRun     = 3'd0,
    KindReg     = 3'd1,
    KindSentNow = 3'd2,
    KindSentIrq = 3'd3,
    KindShut    = 3'd4,
    KindReport  = 3'd5,
    KindClear   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    CauseMotGuar = 3'd0,
    CauseMotGrid = 3'd1,
    CauseReq     = 3'd2,
    CauseOpt     = 3'd3,
    CauseRap     = 3'd4,
    CauseRec     = 3'd5
  } cause_e;

  typedef enum logic [3:0] {
    OpNone,
    OpExec,
    OpForce,
    OpSent,
    OpMot,
    OpReq,
    OpOptScan,
    OpOptRun,
    OpRap,
    OpRec,
    OpFlush
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic            load;
  } cmd_t;

  typedef struct packed {
    logic            is_run;
    logic [CntW-1:0] cnt_mot;
    logic [CntW-1:0] cnt_opt;
    logic [CntW-1:0] cnt_rap;
    logic            req_avail;
    logic            rec_phase;
    logic            push_ok;
    logic            out_free;
  } sts_t;

  // one result word, dispatch_valid in the lowest bit
  typedef struct packed {
    logic             rd;
    logic             want;
    logic [2:0]       cause;
    logic [SlotW-1:0] slot;
    logic             dv;
  } res_t;

  // done bit of a flag index, zero for no flag or a flag beyond the mask
  function automatic logic [FlagBits-1:0] flag_bit(input logic [5:0] k);
    logic [FlagBits-1:0] r;
    r = '0;
    if (k != 6'd0 && k <= 6'(FlagBits)) begin
      r[5'(k - 6'd1)] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtd_ctrl.sv =====
// sequencer of the deadline task dispatcher: walks one item through its steps
// depends on dtd_pkg
`default_nettype none

module dtd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dtd_pkg::sts_t sts_i,
  output dtd_pkg::cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StStart  = 12'b000000000010,
    StExec   = 12'b000000000100,
    StForce  = 12'b000000001000,
    StSent   = 12'b000000010000,
    StMot    = 12'b000000100000,
    StReq    = 12'b000001000000,
    StOpt    = 12'b000010000000,
    StOptRun = 12'b000100000000,
    StRap    = 12'b001000000000,
    StRec    = 12'b010000000000,
    StFlush  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [dtd_pkg::CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = dtd_pkg::OpNone;
    cmd_o.idx  = cnt_q[dtd_pkg::IdxW-1:0];
    cmd_o.load = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StStart;
        end
      end
      StStart: begin
        state_d = sts_i.is_run ? StForce : StExec;
      end
      StExec: begin
        cmd_o.op = dtd_pkg::OpExec;
        state_d  = StFlush;
      end
      StForce: begin
        cmd_o.op = dtd_pkg::OpForce;
        state_d  = StSent;
      end
      StSent: begin
        cmd_o.op = dtd_pkg::OpSent;
        cnt_d    = '0;
        state_d  = StMot;
      end
      StMot: begin
        if (cnt_q < sts_i.cnt_mot) begin
          if (sts_i.push_ok) begin
            cmd_o.op = dtd_pkg::OpMot;
            cnt_d    = cnt_q + 1'b1;
          end
        end else begin
          state_d = StReq;
        end
      end
      StReq: begin
        if (sts_i.rec_phase) begin
          cnt_d   = '0;
          state_d = StRap;
        end else if (sts_i.req_avail) begin
          if (sts_i.push_ok) begin
            cmd_o.op = dtd_pkg::OpReq;
            cnt_d    = '0;
            state_d  = StRap;
          end
        end else begin
          cnt_d   = '0;
          state_d = StOpt;
        end
      end
      StOpt: begin
        if (cnt_q < sts_i.cnt_opt) begin
          cmd_o.op = dtd_pkg::OpOptScan;
          cnt_d    = cnt_q + 1'b1;
        end else begin
          state_d = StOptRun;
        end
      end
      StOptRun: begin
        if (sts_i.push_ok) begin
          cmd_o.op = dtd_pkg::OpOptRun;
          cnt_d    = '0;
          state_d  = StRap;
        end
      end
      StRap: begin
        if (cnt_q < sts_i.cnt_rap) begin
          if (sts_i.push_ok) begin
            cmd_o.op = dtd_pkg::OpRap;
            cnt_d    = cnt_q + 1'b1;
          end
        end else begin
          state_d = StRec;
        end
      end
      StRec: begin
        if (sts_i.push_ok) begin
          cmd_o.op = dtd_pkg::OpRec;
          state_d  = StFlush;
        end
      end
      StFlush: begin
        if (sts_i.out_free) begin
          cmd_o.op = dtd_pkg::OpFlush;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtd_datapath.sv =====
// task table, ordered lists, cycle timing and result staging
// depends on dtd_pkg, driven by dtd_ctrl commands
`default_nettype none

module dtd_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dtd_pkg::cmd_t                cmd_i,
  output dtd_pkg::sts_t                     sts_o,
  input  wire logic [2:0]                   kind_i,
  input  wire logic [dtd_pkg::InDataW-1:0]  data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output dtd_pkg::res_t                     out_res_o,
  output logic                              out_last_o
);

  localparam int SW = dtd_pkg::SlotW;
  localparam int IW = dtd_pkg::IdxW;
  localparam int CW = dtd_pkg::CntW;
  localparam int TW = dtd_pkg::TimeBits;
  localparam int LD = dtd_pkg::ListDepth;
  localparam int NS = dtd_pkg::TaskSlots;
  localparam int FW = dtd_pkg::FlagBits;

  // latched item
  logic [2:0]    kind_q;
  logic [TW-1:0] now_q;
  logic [SW-1:0] slot_q;
  logic [5:0]    types_in_q;
  logic [31:0]   oi_in_q, mi_in_q, meas_q;

  // task table
  logic [5:0]    types_q [NS];
  logic [31:0]   oint_q  [NS];
  logic [31:0]   mint_q  [NS];
  logic [TW-1:0] lrun_q  [NS];
  logic [31:0]   wrt_q   [NS];
  logic [5:0]    fidx_q  [NS];

  // lists
  logic [SW-1:0] req_ent_q [LD];
  logic [SW-1:0] mot_ent_q [LD];
  logic [SW-1:0] rec_ent_q [LD];
  logic [SW-1:0] opt_ent_q [LD];
  logic [SW-1:0] rap_ent_q [LD];
  logic [CW-1:0] req_cnt_q, mot_cnt_q, rec_cnt_q, opt_cnt_q, rap_cnt_q;

  logic [CW-1:0] req_next_q;
  logic [IW-1:0] rec_next_q;
  logic [5:0]    falloc_q;
  logic [FW-1:0] fmask_q, fdone_q;
  logic [TW-1:0] cstart_q, cdl_q, fdl_q;
  logic          rec_phase_q, shut_q, sent_pend_q;

  // optional scan
  logic          found_q;
  logic [SW-1:0] best_q;
  logic [63:0]   maxd_q;

  // result staging
  logic          pend_v_q, out_v_q, out_last_q;
  dtd_pkg::res_t pend_q, out_q;

  // current slot
  logic [IW-1:0] rec_idx;
  logic [SW-1:0] s;
  always_comb begin
    rec_idx = ({1'b0, rec_next_q} < {1'b0, rec_cnt_q}) ? rec_next_q : '0;
    case (cmd_i.op)
      dtd_pkg::OpMot:     s = mot_ent_q[cmd_i.idx];
      dtd_pkg::OpReq:     s = req_ent_q[req_next_q[IW-1:0]];
      dtd_pkg::OpOptScan: s = opt_ent_q[cmd_i.idx];
      dtd_pkg::OpOptRun:  s = best_q;
      dtd_pkg::OpRap:     s = rap_ent_q[cmd_i.idx];
      dtd_pkg::OpRec:     s = rec_ent_q[rec_idx];
      default:            s = slot_q;
    endcase
  end

  logic [5:0]    ty;
  logic [TW-1:0] lr, diff, lr2, lr3;
  logic [31:0]   iv, oi;
  logic [FW-1:0] fb;
  logic          run_ok, mot_first, mot_grid, due, rec_ok, rd;
  logic [63:0]   dlt;
  logic [TW-1:0] rs_cdl, rs_fdl;

  always_comb begin
    ty        = types_q[s];
    lr        = lrun_q[s];
    iv        = mint_q[s];
    oi        = oint_q[s];
    fb        = dtd_pkg::flag_bit(fidx_q[s]);
    run_ok    = !shut_q || ty[dtd_pkg::TShd];
    diff      = now_q - lr;
    mot_first = (fdone_q & fb) == '0;
    mot_grid  = (iv != '0) && (now_q >= lr) && (diff >= TW'(iv));
    lr2       = lr + TW'(iv);
    lr3       = ((now_q - lr2) >= TW'(iv)) ? now_q : lr2;
    due       = !ty[dtd_pkg::TOpt] || (oi == '0) || ((now_q > lr) && (diff > TW'(oi)));
    dlt       = 64'(now_q) - 64'(lr) - 64'(oi);
    rec_ok    = rec_phase_q && (rec_cnt_q != '0) && run_ok && due && (now_q < cdl_q)
                && (TW'(wrt_q[s]) < (cdl_q - now_q));
    rd        = (fmask_q == '0) || ((fdone_q & fmask_q) == fmask_q);
    rs_cdl    = now_q + ((cstart_q == '0) ? TW'(dtd_pkg::ForcePeriod) : (now_q - cstart_q));
    rs_fdl    = now_q + TW'(dtd_pkg::ForcePeriod);
  end

  // result of this step
  logic          emit;
  dtd_pkg::res_t new_res;
  always_comb begin
    emit          = 1'b0;
    new_res.dv    = 1'b1;
    new_res.slot  = s;
    new_res.cause = dtd_pkg::CauseReq;
    new_res.want  = 1'b1;
    new_res.rd    = rd;
    case (cmd_i.op)
      dtd_pkg::OpMot: begin
        emit          = (mot_first || mot_grid) && run_ok;
        new_res.cause = mot_first ? dtd_pkg::CauseMotGuar : dtd_pkg::CauseMotGrid;
      end
      dtd_pkg::OpReq: emit = run_ok;
      dtd_pkg::OpOptRun: begin
        emit          = found_q;
        new_res.cause = dtd_pkg::CauseOpt;
      end
      dtd_pkg::OpRap: begin
        emit          = run_ok;
        new_res.cause = dtd_pkg::CauseRap;
        new_res.want  = 1'b0;
      end
      dtd_pkg::OpRec: begin
        emit          = rec_ok;
        new_res.cause = dtd_pkg::CauseRec;
        new_res.want  = 1'b0;
      end
      default: emit = 1'b0;
    endcase
  end

  logic out_free;
  assign out_free = !out_v_q || out_ready_i;

  // register-time list appends
  logic any_add;
  always_comb begin
    any_add = (types_in_q[dtd_pkg::TReq] && req_cnt_q < CW'(LD))
           || (types_in_q[dtd_pkg::TMot] && mot_cnt_q < CW'(LD))
           || (types_in_q[dtd_pkg::TRec] && rec_cnt_q < CW'(LD))
           || (types_in_q[dtd_pkg::TOpt] && opt_cnt_q < CW'(LD))
           || (types_in_q[dtd_pkg::TRap] && rap_cnt_q < CW'(LD));
  end

  logic do_reg;
  assign do_reg = (cmd_i.op == dtd_pkg::OpExec) && (kind_q == dtd_pkg::KindReg);

  // list entries and latched item, no reset
  always_ff @(posedge clk_i) begin
    if (do_reg) begin
      if (types_in_q[dtd_pkg::TReq] && req_cnt_q < CW'(LD)) req_ent_q[req_cnt_q[IW-1:0]] <= slot_q;
      if (types_in_q[dtd_pkg::TMot] && mot_cnt_q < CW'(LD)) mot_ent_q[mot_cnt_q[IW-1:0]] <= slot_q;
      if (types_in_q[dtd_pkg::TRec] && rec_cnt_q < CW'(LD)) rec_ent_q[rec_cnt_q[IW-1:0]] <= slot_q;
      if (types_in_q[dtd_pkg::TOpt] && opt_cnt_q < CW'(LD)) opt_ent_q[opt_cnt_q[IW-1:0]] <= slot_q;
      if (types_in_q[dtd_pkg::TRap] && rap_cnt_q < CW'(LD)) rap_ent_q[rap_cnt_q[IW-1:0]] <= slot_q;
    end
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      now_q      <= data_i[TW-1:0];
      slot_q     <= data_i[TW+SW-1:TW];
      types_in_q <= data_i[57:52];
      oi_in_q    <= data_i[89:58];
      mi_in_q    <= data_i[121:90];
      meas_q     <= data_i[153:122];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        types_q[i] <= '0;
        oint_q[i]  <= '0;
        mint_q[i]  <= '0;
        lrun_q[i]  <= '0;
        wrt_q[i]   <= '0;
        fidx_q[i]  <= '0;
      end
      req_cnt_q   <= '0;
      mot_cnt_q   <= '0;
      rec_cnt_q   <= '0;
      opt_cnt_q   <= '0;
      rap_cnt_q   <= '0;
      req_next_q  <= '0;
      rec_next_q  <= '0;
      falloc_q    <= '0;
      fmask_q     <= '0;
      fdone_q     <= '0;
      cstart_q    <= '0;
      cdl_q       <= '0;
      fdl_q       <= '0;
      rec_phase_q <= 1'b0;
      shut_q      <= 1'b0;
      sent_pend_q <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      maxd_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_q      <= '0;
      out_v_q     <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // taken word leaves unless a new one moves in this cycle
      if (out_v_q && out_ready_i && !(emit && pend_v_q) && (cmd_i.op != dtd_pkg::OpFlush)) begin
        out_v_q <= 1'b0;
      end

      // staging of an emitted result; the older one moves out
      if (emit) begin
        if (pend_v_q) begin
          out_v_q    <= 1'b1;
          out_q      <= pend_q;
          out_last_q <= 1'b0;
        end
        pend_q   <= new_res;
        pend_v_q <= 1'b1;
      end

      case (cmd_i.op)
        dtd_pkg::OpExec: begin
          case (kind_q)
            dtd_pkg::KindReg: begin
              types_q[slot_q] <= types_in_q;
              oint_q[slot_q]  <= oi_in_q;
              mint_q[slot_q]  <= mi_in_q;
              lrun_q[slot_q]  <= '0;
              wrt_q[slot_q]   <= any_add ? 32'(dtd_pkg::DefaultRuntime) : '0;
              fidx_q[slot_q]  <= ((types_in_q[dtd_pkg::TReq] || types_in_q[dtd_pkg::TMot])
                                  && falloc_q < 6'(FW)) ? falloc_q + 6'd1 : 6'd0;
              if (types_in_q[dtd_pkg::TReq] || types_in_q[dtd_pkg::TMot]) begin
                if (falloc_q < 6'(FW)) begin
                  fmask_q[falloc_q[4:0]] <= 1'b1;
                end
                if (falloc_q != 6'd63) falloc_q <= falloc_q + 6'd1;
              end
              if (types_in_q[dtd_pkg::TReq] && req_cnt_q < CW'(LD)) req_cnt_q <= req_cnt_q + 1'b1;
              if (types_in_q[dtd_pkg::TMot] && mot_cnt_q < CW'(LD)) mot_cnt_q <= mot_cnt_q + 1'b1;
              if (types_in_q[dtd_pkg::TRec] && rec_cnt_q < CW'(LD)) rec_cnt_q <= rec_cnt_q + 1'b1;
              if (types_in_q[dtd_pkg::TOpt] && opt_cnt_q < CW'(LD)) opt_cnt_q <= opt_cnt_q + 1'b1;
              if (types_in_q[dtd_pkg::TRap] && rap_cnt_q < CW'(LD)) rap_cnt_q <= rap_cnt_q + 1'b1;
            end
            dtd_pkg::KindSentNow: begin
              cstart_q    <= now_q;
              cdl_q       <= rs_cdl;
              fdl_q       <= rs_fdl;
              req_next_q  <= '0;
              fdone_q     <= '0;
              rec_phase_q <= 1'b0;
            end
            dtd_pkg::KindSentIrq: sent_pend_q <= 1'b1;
            dtd_pkg::KindShut:    shut_q <= 1'b1;
            dtd_pkg::KindReport: begin
              if (meas_q > wrt_q[slot_q]) wrt_q[slot_q] <= meas_q;
            end
            dtd_pkg::KindClear: begin
              req_cnt_q   <= '0;
              mot_cnt_q   <= '0;
              rec_cnt_q   <= '0;
              opt_cnt_q   <= '0;
              rap_cnt_q   <= '0;
              req_next_q  <= '0;
              rec_next_q  <= '0;
              falloc_q    <= '0;
              fmask_q     <= '0;
              fdone_q     <= '0;
              cstart_q    <= '0;
              cdl_q       <= '0;
              fdl_q       <= '0;
              rec_phase_q <= 1'b0;
            end
            default: ;
          endcase
        end
        dtd_pkg::OpForce: begin
          found_q <= 1'b0;
          maxd_q  <= '0;
          if (now_q >= fdl_q) begin
            cstart_q    <= now_q;
            cdl_q       <= rs_cdl;
            fdl_q       <= rs_fdl;
            req_next_q  <= '0;
            fdone_q     <= '0;
            rec_phase_q <= 1'b0;
          end
        end
        dtd_pkg::OpSent: begin
          if (sent_pend_q) begin
            cstart_q    <= now_q;
            cdl_q       <= rs_cdl;
            fdl_q       <= rs_fdl;
            req_next_q  <= '0;
            fdone_q     <= '0;
            rec_phase_q <= 1'b0;
            sent_pend_q <= 1'b0;
          end
        end
        dtd_pkg::OpMot: begin
          if (mot_first) begin
            if (run_ok) lrun_q[s] <= now_q;
            fdone_q <= fdone_q | fb;
          end else if (mot_grid) begin
            lrun_q[s] <= lr3;
          end
        end
        dtd_pkg::OpReq: begin
          if (run_ok) lrun_q[s] <= now_q;
          fdone_q    <= fdone_q | fb;
          req_next_q <= req_next_q + 1'b1;
        end
        dtd_pkg::OpOptScan: begin
          if (run_ok && due && dlt > maxd_q) begin
            maxd_q  <= dlt;
            best_q  <= s;
            found_q <= 1'b1;
          end
        end
        dtd_pkg::OpOptRun: begin
          if (found_q) lrun_q[s] <= now_q;
          rec_phase_q <= 1'b1;
        end
        dtd_pkg::OpRap: begin
          if (run_ok) lrun_q[s] <= now_q;
        end
        dtd_pkg::OpRec: begin
          if (rec_ok) begin
            lrun_q[s]  <= now_q;
            rec_next_q <= ({1'b0, rec_idx} + 1'b1 == {1'b0, rec_cnt_q}) ? '0 : rec_idx + 1'b1;
          end
        end
        dtd_pkg::OpFlush: begin
          out_v_q    <= 1'b1;
          out_last_q <= 1'b1;
          pend_v_q   <= 1'b0;
          if (pend_v_q) begin
            out_q <= pend_q;
          end else begin
            out_q <= '{rd: rd, default: '0};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.is_run    = (kind_q == dtd_pkg::KindRun);
    sts_o.cnt_mot   = mot_cnt_q;
    sts_o.cnt_opt   = opt_cnt_q;
    sts_o.cnt_rap   = rap_cnt_q;
    sts_o.req_avail = req_next_q < req_cnt_q;
    sts_o.rec_phase = rec_phase_q;
    sts_o.push_ok   = !pend_v_q || out_free;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/deadline_task_dispatcher.sv =====
// deadline task dispatcher: a non-run item passes through start, execute and flush and shows a single word
// a run call steps through force, sentinel, motion, then required or optional scan and run,
// then rapid and recurring, and ends in flush; its pushes and the flush can stall on the output
// one item is in flight at a time; the next word can be taken in the cycle after the final word is staged
// reset (rst_ni low, async) clears the task table, lists, flags and cycle times
// depends on dtd_pkg, dtd_ctrl, dtd_datapath
`default_nettype none

module deadline_task_dispatcher (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input words
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // now_time[47:0], task_slot[51:48], type_bits[57:52], optional_interval[89:58],
  // motion_interval[121:90], measured_runtime[153:122], zero fill to 160
  input  wire logic [dtd_pkg::InDataW-1:0]       s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]                        s_axis_tuser,
  // result words
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // dispatch_valid[0], dispatch_task[4:1], dispatch_cause[7:5], want_runtime[8],
  // required_done[9], zero fill to 16
  output logic [dtd_pkg::OutDataW-1:0]           m_axis_tdata,
  output logic                                   m_axis_tlast
);

  dtd_pkg::cmd_t cmd;
  dtd_pkg::sts_t sts;
  dtd_pkg::res_t res;

  // sequencer: one state per step of the dispatch order
  dtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // state and arithmetic; the newest result is held back so the final one carries tlast
  dtd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(dtd_pkg::OutDataW - $bits(dtd_pkg::res_t))'(0), res};

endmodule

`default_nettype wire

// ===== rtl/core/dtd_checker.sv =====
// port-level checks of the deadline task dispatcher, bound to the top level
// depends on deadline_task_dispatcher_defines.svh and dtd_pkg
`default_nettype none
`include "deadline_task_dispatcher_defines.svh"

module dtd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dtd_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // one item at a time: no word is taken right after another
  `DTD_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")
  // an idle word is always the final word of its item
  `DTD_ASSERT(a_idle_last, (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast, "idle word without tlast")
  // a stalled result word stays
  `DTD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind deadline_task_dispatcher dtd_checker u_chk (.*);

`default_nettype wire

// ===== verif/deadline_task_dispatcher_tb.sv =====
// self-checking testbench for the deadline task dispatcher
// drives input words, predicts every result word and compares field by field
// depends on dtd_pkg and the deadline_task_dispatcher rtl
`timescale 1ns / 100ps

module deadline_task_dispatcher_tb;
  import dtd_pkg::*;

  localparam int NumLists = 5;
  localparam int LReq = 0, LMot = 1, LRec = 2, LOpt = 3, LRap = 4;
  localparam logic [47:0] TimeMask = 48'hFFFF_FFFF_FFFF;

  // one input word as the block sees it
  typedef struct {
    kind_e       kind;
    logic [47:0] now;
    logic [3:0]  slot;
    logic [5:0]  types;
    logic [31:0] opt_iv;
    logic [31:0] mot_iv;
    logic [31:0] runtime;
  } item_t;

  // one expected result word, with its tlast
  typedef struct {
    logic       dv;
    logic [3:0] slot;
    logic [2:0] cause;
    logic       want;
    logic       rd;
    logic       last;
  } disp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  always #2 clk_i = ~clk_i;

  deadline_task_dispatcher DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // ---------------- predictor state ----------------
  logic [5:0]  p_types [TaskSlots];
  logic [31:0] p_opt_iv [TaskSlots];
  logic [31:0] p_mot_iv [TaskSlots];
  logic [47:0] p_last_run [TaskSlots];
  logic [31:0] p_worst [TaskSlots];
  logic [5:0]  p_flag_idx [TaskSlots];
  logic [3:0]  p_list [NumLists][ListDepth];
  int          p_cnt [NumLists];
  int          p_req_next, p_rec_next, p_flag_cnt;
  logic [31:0] p_mask, p_done;
  logic [47:0] p_cyc_start, p_cyc_deadline, p_force_deadline;
  bit          p_rec_phase, p_shutdown, p_sent_pending;

  disp_t dispatch_q[$];
  int    errors = 0;
  bit    quiet = 1'b0;   // no idling in the last part of the run

  function automatic logic [31:0] done_bit(int s);
    int k;
    k = p_flag_idx[s];
    if (k == 0 || k > 32) return 32'd0;
    return 32'd1 << (k - 1);
  endfunction

  function automatic bit all_done();
    return p_mask == 0 || (p_done & p_mask) == p_mask;
  endfunction

  function automatic bit can_run(int s);
    return !p_shutdown || p_types[s][TShd];
  endfunction

  function automatic bit opt_due(int s, logic [47:0] now);
    if (!p_types[s][TOpt] || p_opt_iv[s] == 0) return 1'b1;
    return now > p_last_run[s] && (now - p_last_run[s]) > {16'd0, p_opt_iv[s]};
  endfunction

  function automatic void push_dispatch(int s, cause_e c, bit want);
    disp_t d;
    d = '{dv: 1'b1, slot: 4'(s), cause: c, want: want, rd: all_done(), last: 1'b0};
    dispatch_q.push_back(d);
  endfunction

  function automatic bit try_dispatch(int s, logic [47:0] now, cause_e c, bit want);
    if (!can_run(s)) return 1'b0;
    push_dispatch(s, c, want);
    p_last_run[s] = now;
    return 1'b1;
  endfunction

  function automatic void restart_cycle(logic [47:0] now);
    logic [47:0] period;
    period = (p_cyc_start == 0) ? 48'(ForcePeriod) : (now - p_cyc_start) & TimeMask;
    p_cyc_start = now;
    p_cyc_deadline = now + period;
    p_force_deadline = now + 48'(ForcePeriod);
    p_req_next = 0;
    p_done = 0;
    p_rec_phase = 1'b0;
  endfunction

  function automatic void clear_lists();
    foreach (p_cnt[l]) p_cnt[l] = 0;
    p_req_next = 0; p_rec_next = 0; p_flag_cnt = 0;
    p_mask = 0; p_done = 0;
    p_cyc_start = 0; p_cyc_deadline = 0; p_force_deadline = 0;
    p_rec_phase = 1'b0;
  endfunction

  function automatic void reset_tasks();
    for (int s = 0; s < TaskSlots; s++) begin
      p_types[s] = 0; p_opt_iv[s] = 0; p_mot_iv[s] = 0;
      p_last_run[s] = 0; p_worst[s] = 0; p_flag_idx[s] = 0;
    end
    clear_lists();
    p_shutdown = 1'b0;
    p_sent_pending = 1'b0;
  endfunction

  function automatic void append(int l, int s);
    if (p_cnt[l] >= ListDepth) return;
    p_list[l][p_cnt[l]] = 4'(s);
    p_cnt[l]++;
    p_worst[s] = DefaultRuntime;
  endfunction

  function automatic void register_task(item_t it);
    int s;
    s = it.slot;
    p_types[s] = it.types; p_opt_iv[s] = it.opt_iv; p_mot_iv[s] = it.mot_iv;
    p_last_run[s] = 0; p_worst[s] = 0; p_flag_idx[s] = 0;
    if (it.types[TReq] || it.types[TMot]) begin
      if (p_flag_cnt < 32) begin
        p_mask |= 32'd1 << p_flag_cnt;
        p_flag_idx[s] = 6'(p_flag_cnt + 1);
      end
      if (p_flag_cnt < 63) p_flag_cnt++;
    end
    if (it.types[TReq]) append(LReq, s);
    if (it.types[TMot]) append(LMot, s);
    if (it.types[TRec]) append(LRec, s);
    if (it.types[TOpt]) append(LOpt, s);
    if (it.types[TRap]) append(LRap, s);
  endfunction

  function automatic void run_call(logic [47:0] now);
    int s, idx;
    logic [31:0] f;
    logic [47:0] lr, iv;
    logic [63:0] best_d, d;
    int best;
    bit found, ok;
    if (now >= p_force_deadline) restart_cycle(now);
    if (p_sent_pending) begin
      restart_cycle(now);
      p_sent_pending = 1'b0;
    end
    // motion: guaranteed run until its done bit is set, then the grid
    for (int i = 0; i < p_cnt[LMot]; i++) begin
      s = p_list[LMot][i];
      f = done_bit(s);
      iv = {16'd0, p_mot_iv[s]};
      if ((p_done & f) == 0) begin
        ok = try_dispatch(s, now, CauseMotGuar, 1'b1);
        p_done |= f;
      end else if (iv != 0) begin
        lr = p_last_run[s];
        if (now >= lr && now - lr >= iv) begin
          ok = try_dispatch(s, now, CauseMotGrid, 1'b1);
          lr = lr + iv;
          if (now - lr >= iv) lr = now;
          p_last_run[s] = lr;
        end
      end
    end
    if (!p_rec_phase) begin
      if (p_req_next < p_cnt[LReq]) begin
        s = p_list[LReq][p_req_next];
        ok = try_dispatch(s, now, CauseReq, 1'b1);
        p_done |= done_bit(s);
        p_req_next++;
      end else begin
        // most overdue optional task, strict maximum above zero, 64-bit lateness
        found = 1'b0; best = 0; best_d = 0;
        for (int i = 0; i < p_cnt[LOpt]; i++) begin
          s = p_list[LOpt][i];
          if (!can_run(s) || !opt_due(s, now)) continue;
          d = 64'(now) - 64'(p_last_run[s]) - 64'(p_opt_iv[s]);
          if (d > best_d) begin
            best_d = d; best = s; found = 1'b1;
          end
        end
        if (found) ok = try_dispatch(best, now, CauseOpt, 1'b1);
        p_rec_phase = 1'b1;
      end
    end
    for (int i = 0; i < p_cnt[LRap]; i++)
      ok = try_dispatch(p_list[LRap][i], now, CauseRap, 1'b0);
    if (p_rec_phase && p_cnt[LRec] > 0) begin
      idx = (p_rec_next < p_cnt[LRec]) ? p_rec_next : 0;
      s = p_list[LRec][idx];
      if (!can_run(s) || !opt_due(s, now)) return;
      if (now >= p_cyc_deadline || {16'd0, p_worst[s]} >= p_cyc_deadline - now) return;
      push_dispatch(s, CauseRec, 1'b0);
      p_last_run[s] = now;
      p_rec_next = (idx + 1) % p_cnt[LRec];
    end
  endfunction

  // works out the result words of one input word and queues them
  function automatic void predict_dispatches(item_t it);
    int n0;
    disp_t d;
    n0 = dispatch_q.size();
    case (it.kind)
      KindRun:     run_call(it.now);
      KindReg:     register_task(it);
      KindSentNow: restart_cycle(it.now);
      KindSentIrq: p_sent_pending = 1'b1;
      KindShut:    p_shutdown = 1'b1;
      KindReport:  if (it.runtime > p_worst[it.slot]) p_worst[it.slot] = it.runtime;
      KindClear:   clear_lists();
      default: ;
    endcase
    if (dispatch_q.size() == n0) begin
      d = '{dv: 1'b0, slot: 4'd0, cause: 3'd0, want: 1'b0, rd: all_done(), last: 1'b1};
      dispatch_q.push_back(d);
    end else begin
      dispatch_q[$].last = 1'b1;
    end
  endfunction

  // ---------------- driver ----------------
  // tvalid stays up between back-to-back words; it drops only for a gap or a drain
  task automatic send_word(item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {6'd0, it.runtime, it.mot_iv, it.opt_iv, it.types, it.slot, it.now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_dispatches(it);
  endtask

  function automatic item_t mk(kind_e k, logic [47:0] now, logic [3:0] slot = 0,
                               logic [5:0] types = 0, logic [31:0] oi = 0,
                               logic [31:0] mi = 0, logic [31:0] rt = 0);
    item_t it;
    it = '{kind: k, now: now, slot: slot, types: types, opt_iv: oi, mot_iv: mi, runtime: rt};
    return it;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- receiver and checker ----------------
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    disp_t exp_d;
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[9:0]);
      if (dispatch_q.size() == 0) begin
        $display("%0t: unexpected word %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        exp_d = dispatch_q.pop_front();
        if (got.dv !== exp_d.dv || got.slot !== exp_d.slot || got.cause !== exp_d.cause ||
            got.want !== exp_d.want || got.rd !== exp_d.rd || m_axis_tlast !== exp_d.last ||
            m_axis_tdata[15:10] !== 6'd0) begin
          $display("%0t: mismatch expected dv %b task %0d cause %0d want %b rd %b last %b",
                   $time, exp_d.dv, exp_d.slot, exp_d.cause, exp_d.want, exp_d.rd,
                   exp_d.last);
          $display("%0t:          actual dv %b task %0d cause %0d want %b rd %b last %b",
                   $time, got.dv, got.slot, got.cause, got.want, got.rd, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  // directed table of typed-in rows
  item_t dir_tab[$];
  logic [47:0] clock_us = 0;

  task automatic random_item(bit noise);
    item_t it;
    int r;
    clock_us += $urandom_range(0, 3) == 0 ? $urandom_range(0, 20000) : $urandom_range(0, 600);
    r = $urandom_range(0, 99);
    it = mk(KindRun, clock_us & TimeMask);
    if (noise && $urandom_range(0, 9) == 0) it.now = 48'({$urandom, $urandom} & 64'(TimeMask));
    if (r < 55) it.kind = KindRun;
    else if (r < 70) begin
      it.kind = KindReg;
      it.slot = 4'($urandom_range(0, 15));
      it.types = 6'($urandom_range(0, 63));
      it.opt_iv = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom;
      it.mot_iv = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom;
    end else if (r < 78) it.kind = KindSentNow;
    else if (r < 85) it.kind = KindSentIrq;
    else if (r < 95) begin
      it.kind = KindReport;
      it.slot = 4'($urandom_range(0, 15));
      it.runtime = $urandom_range(0, 1) ? $urandom_range(0, 9000) : $urandom;
    end else if (r < 98) it.kind = KindClear;
    else it.kind = KindShut;
    send_word(it);
  endtask

  initial begin
    disp_t exp0;
    reset_tasks();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle word straight after reset: nothing allocated, so required_done is 1
    send_word(mk(KindRun, 48'd0));
    exp0 = dispatch_q[$];
    if (exp0.dv !== 1'b0 || exp0.rd !== 1'b1) begin
      $display("%0t: mismatch expected idle after reset, actual predictor dv %b rd %b",
               $time, exp0.dv, exp0.rd);
      errors++;
    end

    dir_tab = '{
      mk(KindReg, 48'd0, 4'd0, 6'b100011, 32'd0, 32'd1000),      // required + motion
      mk(KindReg, 48'd0, 4'd1, 6'b000001),                        // required
      mk(KindReg, 48'd0, 4'd2, 6'b001000, 32'd0),                 // optional always due
      mk(KindReg, 48'd0, 4'd3, 6'b001000, 32'hFFFF_FFFF),         // optional max interval
      mk(KindReg, 48'd0, 4'd4, 6'b010000),                        // rapid
      mk(KindReg, 48'd0, 4'd5, 6'b000100),                        // recurring
      mk(KindReg, 48'd0, 4'd15, 6'b111111, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      mk(KindRun, 48'd100),
      mk(KindRun, 48'd200),
      mk(KindRun, 48'd1500),
      mk(KindRun, 48'd2600),
      mk(KindReport, 48'd0, 4'd5, 6'd0, 0, 0, 32'hFFFF_FFFF),     // huge runtime blocks rec
      mk(KindRun, 48'd3000),
      mk(KindSentIrq, 48'd0),
      mk(KindRun, 48'd5000),
      mk(KindRun, 48'd14000),                                     // force deadline passed
      mk(KindSentNow, 48'd15000),
      mk(KindReport, 48'd0, 4'd5, 6'd0, 0, 0, 32'd0),             // smaller runtime, worst kept
      mk(KindRun, 48'hFFFF_FFFF_FFF0),                            // time extreme
      mk(KindShut, 48'd0),
      mk(KindRun, 48'hFFFF_FFFF_FFFF),
      mk(KindClear, 48'd0),
      mk(KindRun, 48'd7)
    };
    foreach (dir_tab[i]) send_word(dir_tab[i]);

    // sender holds off until every result is in
    drain();

    // flags past thirty-two: many required/motion registrations
    for (int i = 0; i < 36; i++)
      send_word(mk(KindReg, 48'd0, 4'(i), 6'(($urandom_range(0, 1) ? 6'b000001 : 6'b000010)
                                             | 6'b100000), 0, 32'($urandom_range(0, 500))));
    for (int i = 0; i < 6; i++) begin
      clock_us += 300;
      send_word(mk(KindRun, clock_us));
    end

    // random part: one clear and task set, then random words with noise allowed on every third
    for (int i = 0; i < 40; i++) begin
      if (i % 40 == 0) begin
        send_word(mk(KindClear, 48'd0));
        for (int k = 0; k < 8; k++)
          send_word(mk(KindReg, 48'd0, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                       $urandom_range(0, 1) ? 32'($urandom_range(0, 2000)) : $urandom,
                       $urandom_range(0, 1) ? 32'($urandom_range(0, 2000)) : $urandom));
      end
      if (i == 30) quiet = 1'b1;
      random_item(i % 3 == 0);
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
